FILE: hw/rtl/link_failover_deadline_fsm_assert.svh
// Assertion macros used by the failover supervisor core (lfd_core).
// Define ASSERT_OFF to compile every check away.
`ifndef LINK_FAILOVER_DEADLINE_FSM_ASSERT_SVH
`define LINK_FAILOVER_DEADLINE_FSM_ASSERT_SVH

`ifndef ASSERT_OFF
// Clocked check, disabled while reset is high.
`define LFD_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked check that also holds during reset.
`define LFD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LFD_ASSERT(lbl, clk, rst, prop, msg)
`define LFD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: hw/rtl/lfd_pkg.sv
// Types, codes and widths shared by the failover supervisor modules.
// No dependencies.
package lfd_pkg;

  localparam int TIME_W = 32;
  localparam int IN_W   = 40;  // 35 payload bits padded to whole bytes
  localparam int OUT_W  = 40;  // 37 payload bits padded to whole bytes
  localparam int CFG_W  = 32;

  typedef enum logic [1:0] {
    MODE_PRIMARY  = 2'd0,
    MODE_OFF_PEND = 2'd1,
    MODE_FALLBACK = 2'd2,
    MODE_RET_PEND = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_ENTER = 2'd1,
    ACT_EXIT  = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    REG_ENABLE          = 2'd0,
    REG_OFFLINE_TIMEOUT = 2'd1,
    REG_RETURN_DELAY    = 2'd2,
    REG_MANUAL_STAY     = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic              enable;
    logic [TIME_W-1:0] offline_timeout;
    logic [TIME_W-1:0] return_delay;
    logic              manual_stay;
  } cfg_t;

  typedef struct packed {
    logic              rules_active;
    logic              session_up;
    logic              link_ready;
    logic [TIME_W-1:0] now_time;
  } tick_t;

  typedef struct packed {
    logic [TIME_W-1:0] armed_deadline;
    action_t           action;
    logic              mode_changed;
    mode_t             next_mode;
  } result_t;

endpackage

FILE: hw/rtl/lfd_cfg_regs.sv
// Configuration register file of the failover supervisor.
// Depends on lfd_pkg.
module lfd_cfg_regs import lfd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  output cfg_t             cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_ENABLE:          cfg.enable          <= cfg_wdata[0];
        REG_OFFLINE_TIMEOUT: cfg.offline_timeout <= cfg_wdata[TIME_W-1:0];
        REG_RETURN_DELAY:    cfg.return_delay    <= cfg_wdata[TIME_W-1:0];
        REG_MANUAL_STAY:     cfg.manual_stay     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

endmodule

FILE: hw/rtl/lfd_core.sv
// Mode state machine and deadline register of the failover supervisor.
// Depends on lfd_pkg and link_failover_deadline_fsm_assert.svh.
`include "link_failover_deadline_fsm_assert.svh"

module lfd_core import lfd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    adv,
  input  tick_t   tick,
  output result_t res
);

  mode_t             mode;
  mode_t             mode_next;
  logic [TIME_W-1:0] deadline;
  logic [TIME_W-1:0] deadline_next;
  logic [TIME_W-1:0] elapsed;
  logic              avail;
  logic              reached;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_PRIMARY;
      deadline <= '0;
    end else if (adv) begin
      mode     <= mode_next;
      deadline <= deadline_next;
    end
  end

  // The deadline counts as reached when now - deadline is not negative
  // as a signed 32-bit value, which survives wraparound of the clock.
  assign elapsed = tick.now_time - deadline;
  assign reached = ~elapsed[TIME_W-1];
  assign avail   = tick.link_ready & tick.session_up;

  always_comb begin
    mode_next        = mode;
    deadline_next    = deadline;
    res.mode_changed = 1'b0;
    res.action       = ACT_NONE;
    if (!cfg.enable) begin
      if (mode != MODE_PRIMARY) begin
        mode_next        = MODE_PRIMARY;
        deadline_next    = '0;
        res.mode_changed = 1'b1;
      end
      if (tick.rules_active) res.action = ACT_EXIT;
    end else begin
      case (mode)
        MODE_PRIMARY: begin
          if (!avail && (cfg.offline_timeout != '0)) begin
            mode_next        = MODE_OFF_PEND;
            deadline_next    = tick.now_time + cfg.offline_timeout;
            res.mode_changed = 1'b1;
          end
        end
        MODE_OFF_PEND: begin
          if (avail) begin
            mode_next        = MODE_PRIMARY;
            deadline_next    = '0;
            res.mode_changed = 1'b1;
          end else if (reached) begin
            res.action       = ACT_ENTER;
            mode_next        = MODE_FALLBACK;
            deadline_next    = '0;
            res.mode_changed = 1'b1;
          end
        end
        MODE_FALLBACK: begin
          // While manual stay is set the block stays in fallback.
          if (avail && !cfg.manual_stay) begin
            if (cfg.return_delay == '0) begin
              res.action    = ACT_EXIT;
              mode_next     = MODE_PRIMARY;
              deadline_next = '0;
            end else begin
              mode_next     = MODE_RET_PEND;
              deadline_next = tick.now_time + cfg.return_delay;
            end
            res.mode_changed = 1'b1;
          end
        end
        default: begin
          if (!avail) begin
            mode_next        = MODE_FALLBACK;
            deadline_next    = '0;
            res.mode_changed = 1'b1;
          end else if (reached) begin
            res.action       = ACT_EXIT;
            mode_next        = MODE_PRIMARY;
            deadline_next    = '0;
            res.mode_changed = 1'b1;
          end
        end
      endcase
    end
    res.next_mode      = mode_next;
    res.armed_deadline = deadline_next;
  end

  `LFD_ASSERT(a_primary_no_deadline, clk, rst, (mode == MODE_PRIMARY) |-> (deadline == 32'd0), "primary mode holds a deadline")
  `LFD_ASSERT(a_fallback_no_deadline, clk, rst, (mode == MODE_FALLBACK) |-> (deadline == 32'd0), "fallback mode holds a deadline")
  `LFD_ASSERT(a_disabled_forces_primary, clk, rst, (adv && !cfg.enable) |=> (mode == MODE_PRIMARY), "disabled tick left a non-primary mode")
  `LFD_ASSERT(a_enter_from_pending, clk, rst, (adv && (res.action == ACT_ENTER)) |-> (mode == MODE_OFF_PEND), "fallback entered from a mode other than offline pending")

endmodule

FILE: hw/rtl/link_failover_deadline_fsm.sv
// Failover supervisor: one evaluation tick in, one mode decision out.
//
// Input stream s_*: each item is one tick carrying the current millisecond
// time and the link, session and rules flags. Output stream m_*: one item per
// tick with the new mode, a changed flag, the fallback action and the deadline
// that is armed after the tick. The configuration port writes one register
// per cycle while cfg_we is high and should only be used while no item is in
// flight.
//
// An accepted tick sits in an input register, then the mode machine evaluates
// it as it leaves that register and the result is captured in the output
// register, which raises m_tvalid. A new tick is taken every clock while the
// output is not stalled by m_tready; the mode and deadline registers, updated
// as each tick leaves the input register, allow that rate. When m_tready is
// low the output register holds its item, the input register fills behind it
// and s_tready drops. Reset clears the valid flags of both registers, all
// configuration, and puts the machine in primary mode with no deadline.
// Depends on lfd_pkg, lfd_cfg_regs and lfd_core.
module link_failover_deadline_fsm import lfd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // now_time[31:0], link_ready[32], session_up[33], rules_active[34], zero pad
  input  logic [IN_W-1:0]  s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  // next_mode[1:0], mode_changed[2], action[4:3], armed_deadline[36:5], zero pad
  output logic [OUT_W-1:0] m_tdata,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  cfg_t    cfg;
  tick_t   tick;
  result_t res;
  logic    in_valid;
  logic    out_free;
  logic    adv;

  lfd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  lfd_core u_core (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .adv  (adv),
    .tick (tick),
    .res  (res)
  );

  assign out_free = !m_tvalid || m_tready;
  assign adv      = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      tick <= s_tdata[$bits(tick_t)-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {{(OUT_W-$bits(result_t)){1'b0}}, res};
    end
  end

endmodule
